>>> rtl/core/skinning_palette_composer_macros.svh
// Assertion macros shared by the palette composer RTL.
`ifndef SKINNING_PALETTE_COMPOSER_MACROS_SVH
`define SKINNING_PALETTE_COMPOSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/spc_pkg.sv
// Shared constants and helper functions of the palette composer.
package spc_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [2:0] MODE_IB   = 3'd0;
  localparam logic [2:0] MODE_ROOT = 3'd1;
  localparam logic [2:0] MODE_ROT  = 3'd2;
  localparam logic [2:0] MODE_TRN  = 3'd3;
  localparam logic [2:0] MODE_CMP  = 3'd4;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Quaternion product order: xx yy zz xy xz yz xw yw zw.
  function automatic logic [1:0] quat_a(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd3, 4'd4, 4'd6: return 2'd0;
      4'd1, 4'd5, 4'd7:       return 2'd1;
      default:                return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] quat_b(input logic [3:0] idx);
    case (idx)
      4'd0:             return 2'd0;
      4'd1, 4'd3:       return 2'd1;
      4'd2, 4'd4, 4'd5: return 2'd2;
      default:          return 2'd3;
    endcase
  endfunction

endpackage

>>> rtl/core/skinning_palette_composer.sv
// Top level of the skinning bone palette composer.
//
// One request at a time. A load request (inverse-bind row, root row, rotation,
// translation) is stored when accepted, except an inverse-bind row, which is
// written from a load state because the inverse-bind RAM takes one word per
// cycle. A compute request presents four palette rows after these steps: 9
// quaternion products, one rotation step, 12 scale products, 64 products for
// local*parent-global, 64 products for inverse-bind*global, each batch through
// one 32x32 multiply pipeline (operand select, multiply, round, accumulate)
// that drains before the next batch starts. Globals and inverse-bind
// matrices live in two RAMs of MAX_JOINTS*16 words with registered reads;
// root matrix, staged pose and working matrices sit in flops. Requests
// with joint >= MAX_JOINTS and unused modes produce nothing.
`include "skinning_palette_composer_macros.svh"

module skinning_palette_composer #(
  parameter int MAX_JOINTS = spc_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = spc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [5:0]         joint,
  input  logic [1:0]         row,
  input  logic signed [6:0]  parent,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic signed [31:0] v2,
  input  logic signed [31:0] v3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_joint,
  output logic [1:0]         out_row,
  output logic signed [31:0] m0,
  output logic signed [31:0] m1,
  output logic signed [31:0] m2,
  output logic signed [31:0] m3,
  output logic               last_row
);

  localparam int ADDR_W = $clog2(MAX_JOINTS * 16);
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] ONE68 = 68'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_IBLD = 4'd1;
  localparam logic [3:0] ST_QUAT = 4'd2;
  localparam logic [3:0] ST_ROT  = 4'd3;
  localparam logic [3:0] ST_LOC  = 4'd4;
  localparam logic [3:0] ST_GLB  = 4'd5;
  localparam logic [3:0] ST_PAL  = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;

  localparam logic [1:0] PH_Q = 2'd0;
  localparam logic [1:0] PH_L = 2'd1;
  localparam logic [1:0] PH_G = 2'd2;
  localparam logic [1:0] PH_P = 2'd3;

  logic [3:0] state;
  logic [6:0] cnt;

  // Latched request fields.
  logic [5:0]         jreg;
  logic [1:0]         rreg;
  logic [5:0]         prt;
  logic               use_root;
  logic signed [31:0] vin  [0:3];
  logic signed [31:0] scl  [0:3];

  // Flop state and working matrices.
  logic signed [31:0] root [0:15];
  logic signed [31:0] pose [0:6];
  logic signed [63:0] qv   [0:8];
  logic signed [31:0] rot4 [0:15];
  logic signed [31:0] loc  [0:15];
  logic signed [31:0] glb  [0:15];
  logic signed [31:0] pal  [0:15];
  logic signed [63:0] acc;

  // Multiply pipeline.
  logic               pv1, pv2, pv3;
  logic [1:0]         ph1, ph2, ph3;
  logic [5:0]         idx1, idx2, idx3;
  logic signed [63:0] prod, fprod;
  logic signed [31:0] opa, opb;
  logic signed [63:0] acc_sum;

  logic        accept, joint_ok, issue, drained;
  logic [6:0]  issue_cnt;
  logic [1:0]  cur_ph;

  logic              g_we, ib_we;
  logic [ADDR_W-1:0] g_waddr, g_raddr, ib_waddr, ib_raddr;
  logic [31:0]       g_rdata, ib_rdata;
  logic signed [31:0] g_wdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign joint_ok = 9'(joint) < 9'(MAX_JOINTS);

  // Batch length and pipeline tag for each compute step.
  always_comb begin
    unique case (state)
      ST_QUAT: begin issue_cnt = 7'd9;  cur_ph = PH_Q; end
      ST_LOC:  begin issue_cnt = 7'd12; cur_ph = PH_L; end
      ST_GLB:  begin issue_cnt = 7'd64; cur_ph = PH_G; end
      ST_PAL:  begin issue_cnt = 7'd64; cur_ph = PH_P; end
      default: begin issue_cnt = 7'd0;  cur_ph = PH_Q; end
    endcase
  end

  assign issue   = cnt < issue_cnt;
  assign drained = !pv1 && !pv2 && !pv3;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept && joint_ok && mode == spc_pkg::MODE_IB) begin
            state <= ST_IBLD;
          end else if (accept && joint_ok && mode == spc_pkg::MODE_CMP) begin
            state <= ST_QUAT;
          end
        end
        ST_IBLD: begin
          cnt <= cnt + 7'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end
        end
        ST_QUAT, ST_LOC, ST_GLB, ST_PAL: begin
          if (issue) begin
            cnt <= cnt + 7'd1;
          end else if (drained) begin
            cnt <= '0;
            unique case (state)
              ST_QUAT: state <= ST_ROT;
              ST_LOC:  state <= ST_GLB;
              ST_GLB:  state <= ST_PAL;
              default: state <= ST_EMIT;
            endcase
          end
        end
        ST_ROT: begin
          state <= ST_LOC;
        end
        ST_EMIT: begin
          if (out_ready) begin
            cnt <= cnt + 7'd1;
            if (cnt[1:0] == 2'd3) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Capture request payload and update flop-held stores.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (mode)
        spc_pkg::MODE_IB: begin
          jreg   <= joint;
          rreg   <= row;
          vin[0] <= v0;
          vin[1] <= v1;
          vin[2] <= v2;
          vin[3] <= v3;
        end
        spc_pkg::MODE_ROOT: begin
          root[{row, 2'd0}] <= v0;
          root[{row, 2'd1}] <= v1;
          root[{row, 2'd2}] <= v2;
          root[{row, 2'd3}] <= v3;
        end
        spc_pkg::MODE_ROT: begin
          pose[0] <= v0;
          pose[1] <= v1;
          pose[2] <= v2;
          pose[3] <= v3;
        end
        spc_pkg::MODE_TRN: begin
          pose[4] <= v0;
          pose[5] <= v1;
          pose[6] <= v2;
        end
        spc_pkg::MODE_CMP: begin
          jreg     <= joint;
          prt      <= parent[5:0];
          // Parent must be non-negative and below this joint, else use root.
          use_root <= parent[6] || (parent[5:0] >= joint);
          scl[0]   <= v0;
          scl[1]   <= v1;
          scl[2]   <= v2;
          scl[3]   <= '0;
        end
        default: begin
        end
      endcase
    end
    // Form rotation rows from the quaternion products; build the fixed local parts.
    if (state == ST_ROT) begin
      rot4[0]  <= spc_pkg::sat32(ONE68 - ((68'(qv[1]) + 68'(qv[2])) <<< 1));
      rot4[1]  <= spc_pkg::sat32((68'(qv[3]) + 68'(qv[8])) <<< 1);
      rot4[2]  <= spc_pkg::sat32((68'(qv[4]) - 68'(qv[7])) <<< 1);
      rot4[3]  <= '0;
      rot4[4]  <= spc_pkg::sat32((68'(qv[3]) - 68'(qv[8])) <<< 1);
      rot4[5]  <= spc_pkg::sat32(ONE68 - ((68'(qv[0]) + 68'(qv[2])) <<< 1));
      rot4[6]  <= spc_pkg::sat32((68'(qv[5]) + 68'(qv[6])) <<< 1);
      rot4[7]  <= '0;
      rot4[8]  <= spc_pkg::sat32((68'(qv[4]) + 68'(qv[7])) <<< 1);
      rot4[9]  <= spc_pkg::sat32((68'(qv[5]) - 68'(qv[6])) <<< 1);
      rot4[10] <= spc_pkg::sat32(ONE68 - ((68'(qv[0]) + 68'(qv[1])) <<< 1));
      rot4[11] <= '0;
      rot4[12] <= '0;
      rot4[13] <= '0;
      rot4[14] <= '0;
      rot4[15] <= '0;
      loc[3]   <= '0;
      loc[7]   <= '0;
      loc[11]  <= '0;
      loc[12]  <= pose[4];
      loc[13]  <= pose[5];
      loc[14]  <= pose[6];
      loc[15]  <= ONE32;
    end
    // Retire one rounded product from the pipeline tail.
    if (pv3) begin
      unique case (ph3)
        PH_Q: qv[idx3[3:0]] <= fprod;
        PH_L: begin
          if (idx3[1:0] != 2'd3) begin
            loc[idx3[3:0]] <= spc_pkg::sat32(68'(fprod));
          end
        end
        PH_G: begin
          acc <= acc_sum;
          if (idx3[1:0] == 2'd3) begin
            glb[idx3[5:2]] <= spc_pkg::sat32(68'(acc_sum));
          end
        end
        default: begin
          acc <= acc_sum;
          if (idx3[1:0] == 2'd3) begin
            pal[idx3[5:2]] <= spc_pkg::sat32(68'(acc_sum));
          end
        end
      endcase
    end
  end

  // Restart the dot product on its first term.
  assign acc_sum = ((idx3[1:0] == 2'd0) ? 64'sd0 : acc) + fprod;

  // Operand select; RAM data is aligned with stage one. Index is {i, j, k}.
  always_comb begin
    unique case (ph1)
      PH_Q: begin
        opa = pose[{1'b0, spc_pkg::quat_a(idx1[3:0])}];
        opb = pose[{1'b0, spc_pkg::quat_b(idx1[3:0])}];
      end
      PH_L: begin
        opa = scl[idx1[3:2]];
        opb = rot4[idx1[3:0]];
      end
      PH_G: begin
        opa = loc[{idx1[5:4], idx1[1:0]}];
        opb = use_root ? root[{idx1[1:0], idx1[3:2]}] : $signed(g_rdata);
      end
      default: begin
        opa = $signed(ib_rdata);
        opb = glb[{idx1[1:0], idx1[3:2]}];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
      pv3 <= 1'b0;
    end else begin
      pv1 <= issue;
      pv2 <= pv1;
      pv3 <= pv2;
    end
  end

  always_ff @(posedge clk) begin
    ph1   <= cur_ph;
    idx1  <= cnt[5:0];
    ph2   <= ph1;
    idx2  <= idx1;
    prod  <= opa * opb;
    ph3   <= ph2;
    idx3  <= idx2;
    // Round half up: floor((p + half) / 2^FRAC_BITS).
    fprod <= (prod + HALF) >>> FRAC_BITS;
  end

  // Global store: write joint's global, read the parent's.
  assign g_we    = pv3 && (ph3 == PH_G) && (idx3[1:0] == 2'd3);
  assign g_waddr = ADDR_W'({jreg, idx3[5:2]});
  assign g_wdata = spc_pkg::sat32(68'(acc_sum));
  assign g_raddr = ADDR_W'({prt, cnt[1:0], cnt[3:2]});

  // Inverse-bind store: one word per load cycle, read by row during the palette step.
  assign ib_we    = (state == ST_IBLD);
  assign ib_waddr = ADDR_W'({jreg, rreg, cnt[1:0]});
  assign ib_raddr = ADDR_W'({jreg, cnt[5:4], cnt[1:0]});

  spc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_JOINTS * 16)
  ) u_glb_ram (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_waddr),
    .wdata(g_wdata),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  spc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_JOINTS * 16)
  ) u_ib_ram (
    .clk  (clk),
    .we   (ib_we),
    .waddr(ib_waddr),
    .wdata(vin[cnt[1:0]]),
    .raddr(ib_raddr),
    .rdata(ib_rdata)
  );

  // Present palette rows one by one.
  assign out_valid = (state == ST_EMIT);
  assign out_joint = jreg;
  assign out_row   = cnt[1:0];
  assign m0        = pal[{cnt[1:0], 2'd0}];
  assign m1        = pal[{cnt[1:0], 2'd1}];
  assign m2        = pal[{cnt[1:0], 2'd2}];
  assign m3        = pal[{cnt[1:0], 2'd3}];
  assign last_row  = (cnt[1:0] == 2'd3);

  `SPC_ASSERT_NOW(a_no_accept_while_emit, out_valid, !in_ready, "request taken during emit")
  `SPC_ASSERT_NOW(a_pipe_idle, state == ST_IDLE, drained, "multiply pipeline busy while idle")
  `SPC_ASSERT_NOW(a_gwrite_phase, g_we, state == ST_GLB, "global write outside global step")
  `SPC_ASSERT_NEXT(a_emit_last, out_valid && out_ready && last_row, state == ST_IDLE,
    "emit did not end after last row")

endmodule

>>> rtl/core/spc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
